>>> src/glu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glu_pkg
// Shared types and constants for the divisor / multiple unit.
// ----------------------------------------------------------------------------
package glu_pkg;

   localparam int OPERAND_BITS = 32;
   localparam int RESULT_BITS  = 64;

   typedef enum logic {
      FUNC_GCD = 1'b0,
      FUNC_LCM = 1'b1
   } func_type;

   // Status that the divisor unit hands back to the sequencer.
   typedef struct packed {
      logic done;
      logic is_zero;
   } gcd_status_type;

endpackage
`default_nettype wire

>>> src/gcd_lcm_unit_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_lcm_unit_core
// Greatest common divisor or least common multiple of two unsigned operands.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The unit takes one request at a time: req_stall
// is high after the accepted beat until the sequencer is back in idle. The
// divisor comes from a binary GCD loop that does one shift or one
// subtract-and-shift per cycle; a zero operand skips the loop. A multiple
// then adds a restoring divide of operand_a by the divisor and a WIDTH x
// WIDTH multiply by operand_b, so the time to the response beat depends on
// the mode and the operands. The result sits in an output register, so a
// new request is taken while the previous response still waits under
// rsp_stall. Operand bits above WIDTH are ignored. A multiple asked with both
// operands zero returns 0 and raises rsp_zero_divide_flag; divisor mode never
// raises it.
// ----------------------------------------------------------------------------
module gcd_lcm_unit_core #(
   parameter int WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_func,
   input  wire logic [glu_pkg::OPERAND_BITS-1:0]    req_operand_a,
   input  wire logic [glu_pkg::OPERAND_BITS-1:0]    req_operand_b,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [glu_pkg::RESULT_BITS-1:0]     rsp_result_value,
   output logic                                     rsp_zero_divide_flag
);
   import glu_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV,
      ST_MUL,
      ST_FINISH
   } state_type;

   state_type              state_ff;
   func_type               func_ff;
   logic [WIDTH-1:0]       a_ff;
   logic [WIDTH-1:0]       b_ff;
   logic [2*WIDTH-1:0]     value_ff;
   logic                   flag_ff;
   logic                   gcd_start_ff;
   logic                   div_start_ff;
   logic                   rsp_valid_ff;
   logic [RESULT_BITS-1:0] rsp_value_ff;
   logic                   rsp_flag_ff;

   gcd_status_type         gcd_status;
   logic [WIDTH-1:0]       gcd_value;
   logic                   div_done;
   logic [WIDTH-1:0]       quotient;
   logic [2*WIDTH-1:0]     product_in;
   logic                   accept_in;
   logic                   slot_free_in;

   assign accept_in    = req_valid && !req_stall;
   // output register is free if empty or being drained this cycle
   assign slot_free_in = !rsp_valid_ff || !rsp_stall;
   assign product_in   = (2*WIDTH)'(quotient) * (2*WIDTH)'(b_ff);

   glu_binary_gcd #(
      .WIDTH (WIDTH)
   ) u_gcd (
      .clock     (clock),
      .reset     (reset),
      .start     (gcd_start_ff),
      .op_x      (a_ff),
      .op_y      (b_ff),
      .status    (gcd_status),
      .gcd_value (gcd_value)
   );

   glu_divider #(
      .WIDTH (WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (a_ff),
      .divisor  (gcd_value),
      .done     (div_done),
      .quotient (quotient)
   );

   // sequencer: hold state, start pulses and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gcd_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // pulse each unit's start on the cycle after its hand-off
         gcd_start_ff <= (state_ff == ST_IDLE) && accept_in;
         div_start_ff <= (state_ff == ST_GCD) && gcd_status.done &&
                         (func_ff == FUNC_LCM) && !gcd_status.is_zero;
         // load the response from finish, drop it once taken
         if (state_ff == ST_FINISH && slot_free_in) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept_in) begin
                  func_ff      <= func_type'(req_func);
                  a_ff         <= req_operand_a[WIDTH-1:0];
                  b_ff         <= req_operand_b[WIDTH-1:0];
                  state_ff     <= ST_GCD;
               end
            end
            ST_GCD: begin
               if (gcd_status.done) begin
                  if (func_ff == FUNC_GCD) begin
                     value_ff <= (2*WIDTH)'(gcd_value);
                     flag_ff  <= 1'b0;
                     state_ff <= ST_FINISH;
                  end else if (gcd_status.is_zero) begin
                     // both operands zero: no divide, raise the flag
                     value_ff <= '0;
                     flag_ff  <= 1'b1;
                     state_ff <= ST_FINISH;
                  end else begin
                     state_ff     <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               // (a / g) * b, exact and within double width
               value_ff <= product_in;
               flag_ff  <= 1'b0;
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               // hold the result until the output register frees up
               if (slot_free_in) begin
                  rsp_value_ff <= RESULT_BITS'(value_ff);
                  rsp_flag_ff  <= flag_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall            = state_ff != ST_IDLE;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_value     = rsp_value_ff;
   assign rsp_zero_divide_flag = rsp_flag_ff;

endmodule
`default_nettype wire

>>> src/glu_binary_gcd.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glu_binary_gcd
// Iterative binary divisor: one shift or one subtract-and-shift per cycle.
// ----------------------------------------------------------------------------
module glu_binary_gcd #(
   parameter int WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [WIDTH-1:0]      op_x,
   input  wire logic [WIDTH-1:0]      op_y,
   output glu_pkg::gcd_status_type    status,
   output logic      [WIDTH-1:0]      gcd_value
);
   import glu_pkg::*;

   localparam int KBITS = $clog2(WIDTH);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type              state_ff;
   logic                   done_ff;
   logic                   zero_ff;
   logic [WIDTH-1:0]       u_ff;
   logic [WIDTH-1:0]       v_ff;
   logic [KBITS-1:0]       k_ff;
   logic [WIDTH-1:0]       result_ff;
   logic [WIDTH-1:0]       diff_in;
   logic                   u_gt_v;

   // shared compare and subtract
   always_comb begin
      u_gt_v  = u_ff > v_ff;
      diff_in = u_gt_v ? (u_ff - v_ff) : (v_ff - u_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         zero_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               // a zero operand finishes at once
               done_ff <= start && (op_x == '0 || op_y == '0);
               if (start) begin
                  if (op_x == '0 || op_y == '0) begin
                     result_ff <= op_x | op_y;
                     zero_ff   <= (op_x | op_y) == '0;
                  end else begin
                     u_ff     <= op_x;
                     v_ff     <= op_y;
                     k_ff     <= '0;
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_RUN: begin
               done_ff <= u_ff == v_ff;
               if (u_ff == v_ff) begin
                  result_ff <= u_ff << k_ff;
                  zero_ff   <= 1'b0;
                  state_ff  <= ST_IDLE;
               end else if (!u_ff[0] && !v_ff[0]) begin
                  u_ff <= u_ff >> 1;
                  v_ff <= v_ff >> 1;
                  k_ff <= k_ff + 1'b1;
               end else if (!u_ff[0]) begin
                  u_ff <= u_ff >> 1;
               end else if (!v_ff[0]) begin
                  v_ff <= v_ff >> 1;
               end else if (u_gt_v) begin
                  u_ff <= diff_in >> 1;
               end else begin
                  v_ff <= diff_in >> 1;
               end
            end
            default: begin
               done_ff  <= 1'b0;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign status    = gcd_status_type'{done: done_ff, is_zero: zero_ff};
   assign gcd_value = result_ff;

endmodule
`default_nettype wire

>>> src/glu_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glu_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module glu_divider #(
   parameter int WIDTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [WIDTH-1:0]  dividend,
   input  wire logic [WIDTH-1:0]  divisor,
   output logic                   done,
   output logic      [WIDTH-1:0]  quotient
);
   import glu_pkg::*;

   localparam int CBITS = $clog2(WIDTH);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type           state_ff;
   logic                done_ff;
   logic [WIDTH-1:0]    rem_ff;
   logic [WIDTH-1:0]    quo_ff;
   logic [WIDTH-1:0]    div_ff;
   logic [CBITS-1:0]    cnt_ff;
   logic [WIDTH:0]      shifted;
   logic [WIDTH:0]      trial;
   logic                fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      trial   = shifted - {1'b0, div_ff};
      fits    = shifted >= {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               done_ff <= 1'b0;
               if (start) begin
                  rem_ff   <= '0;
                  quo_ff   <= dividend;
                  div_ff   <= divisor;
                  cnt_ff   <= CBITS'(WIDTH - 1);
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               rem_ff  <= fits ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
               quo_ff  <= {quo_ff[WIDTH-2:0], fits};
               cnt_ff  <= cnt_ff - 1'b1;
               done_ff <= cnt_ff == '0;
               if (cnt_ff == '0) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               done_ff  <= 1'b0;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire
